/* hw/rtl/sgd_pkg.sv */
// Shared widths, reset value and result layout of the seconds-to-date converter.
`default_nettype none

package sgd_pkg;

    localparam int SEC_W   = 64;
    localparam int BASE_W  = 40;
    localparam int YEAR_W  = 41;
    localparam int YDAY_W  = 9;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int TDATA_W = 64;

    localparam logic signed [BASE_W-1:0] YEAR_BASE_RESET = -40'sd292277022399;

    typedef struct packed {
        logic [MDAY_W-1:0]  month_day;
        logic [MONTH_W-1:0] month;
        logic [YDAY_W-1:0]  yday;
        logic [YEAR_W-1:0]  year;
    } sgd_result_t;

endpackage

`default_nettype wire

/* hw/rtl/seconds_to_gregorian_date.sv */
// Top level: stream ports, base-year register, output register and checks.
// Path: an accepted word passes the 24 core stages, then the output register, before m_tvalid rises.
// Throughput: one word per cycle while s_tready is high; the 24-stage datapath moves as one unit.
// The pipeline keeps advancing while a result waits, until its last stage fills.
// Reset (aresetn low, synchronous) empties the pipeline and sets year_base.
`default_nettype none

module seconds_to_gregorian_date import sgd_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SEC_W-1:0]   s_tdata,   // abs_seconds[63:0]
    input  wire logic               s_tuser,   // full_date
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // year[40:0], yday[49:41],
                                               // month[53:50], month_day[58:54]
    input  wire logic               cfg_we,
    input  wire logic [BASE_W-1:0]  cfg_wdata  // year_base
);

    logic [BASE_W-1:0] base_reg;
    logic              out_vld_reg;
    sgd_result_t       out_res_reg;
    logic              adv;
    logic              core_vld;
    sgd_result_t       core_res;

    assign adv      = !(core_vld && out_vld_reg && !m_tready);
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= YEAR_BASE_RESET;
        end else if (cfg_we) begin
            base_reg <= cfg_wdata;
        end
    end

    sgd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_seconds (s_tdata),
        .in_full    (s_tuser),
        .year_base  (base_reg),
        .out_valid  (core_vld),
        .out_result (core_res)
    );

    // hold the word until taken; load when the last stage moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv && core_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && core_vld) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'(out_res_reg);

    a_yday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res_reg.yday != 9'd0) && (out_res_reg.yday <= 9'd366))
        else $error("year day out of range");

    a_date_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res_reg.month == 4'd0)) |-> (out_res_reg.month_day == 5'd0))
        else $error("month day without month");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (core_vld && !s_tready) |=> core_vld)
        else $error("stalled result lost");

    a_free_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("input blocked with empty output register");

endmodule

`default_nettype wire

/* hw/rtl/sgd_core.sv */
// Pipelined datapath: seconds to day count, cycle split, leap test and month lookup.
`default_nettype none

module sgd_core import sgd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [SEC_W-1:0]  in_seconds,
    input  wire logic              in_full,
    input  wire logic [BASE_W-1:0] year_base,
    output logic                   out_valid,
    output sgd_result_t            out_result
);

    localparam int STAGES = 24;

    localparam int DAY_DIV = 675;
    localparam logic [29:0] DAY_MAGIC = 30'(((64'd1 << 39) + 64'd674) / 64'd675);
    localparam int CYC_DAYS = 146097;
    localparam logic [30:0] CYC_MAGIC = 31'(((64'd1 << 48) + 64'd146096) / 64'd146097);
    localparam int CENT_DAYS = 36524;
    localparam int QUAD_DAYS = 1461;
    localparam logic [16:0] QUAD_MAGIC = 17'(((64'd1 << 27) + 64'd1460) / 64'd1461);
    localparam int YEAR_DAYS = 365;
    localparam logic [22:0] M25_MAGIC = 23'(((64'd1 << 27) + 64'd24) / 64'd25);
    localparam logic [9:0]  MON_MAGIC = 10'(((64'd1 << 14) + 64'd30) / 64'd31);
    localparam logic [8:0]  LEAP_DAY = 9'd59;
    localparam logic [3:0]  LAST_MONTH = 4'd11;
    localparam logic [3:0]  FEB = 4'd2;
    localparam logic [4:0]  FEB_LAST = 5'd29;

    function automatic logic [18:0] day_quot(input logic [28:0] x);
        logic [58:0] p;
        p = {30'd0, x} * {29'd0, DAY_MAGIC};
        return p[57:39];
    endfunction

    function automatic logic [9:0] day_rem(input logic [28:0] x, input logic [18:0] q);
        logic [28:0] t;
        t = x - ({10'd0, q} * 29'(DAY_DIV));
        return t[9:0];
    endfunction

    function automatic logic [11:0] cyc_quot(input logic [29:0] x);
        logic [60:0] p;
        p = {31'd0, x} * {30'd0, CYC_MAGIC};
        return p[59:48];
    endfunction

    function automatic logic [17:0] cyc_rem(input logic [29:0] x, input logic [11:0] q);
        logic [29:0] t;
        t = x - ({18'd0, q} * 30'(CYC_DAYS));
        return t[17:0];
    endfunction

    function automatic logic [4:0] quad_quot(input logic [15:0] x);
        logic [32:0] p;
        p = {17'd0, x} * {16'd0, QUAD_MAGIC};
        return p[31:27];
    endfunction

    function automatic logic [10:0] quad_rem(input logic [15:0] x, input logic [4:0] q);
        logic [15:0] t;
        t = x - ({11'd0, q} * 16'(QUAD_DAYS));
        return t[10:0];
    endfunction

    function automatic logic [17:0] m25_quot(input logic [21:0] x);
        logic [44:0] p;
        p = {23'd0, x} * {22'd0, M25_MAGIC};
        return p[44:27];
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] full_reg;

    logic [28:0] s1_x_reg;   logic [18:0] s1_q_reg;   logic [37:0] s1_sec_reg;
    logic [9:0]  s2_hi_reg;  logic [9:0]  s2_r_reg;   logic [37:0] s2_sec_reg;
    logic [9:0]  s3_hi_reg;  logic [28:0] s3_x_reg;   logic [18:0] s3_q_reg;
    logic [18:0] s3_sec_reg;
    logic [28:0] s4_hi_reg;  logic [9:0]  s4_r_reg;   logic [18:0] s4_sec_reg;
    logic [47:0] s5_day_reg;
    logic [29:0] s6_x_reg;   logic [11:0] s6_q_reg;   logic [35:0] s6_rest_reg;
    logic [11:0] s7_n_reg;   logic [17:0] s7_r_reg;   logic [35:0] s7_rest_reg;
    logic [11:0] s8_n_reg;   logic [29:0] s8_x_reg;   logic [11:0] s8_q_reg;
    logic [23:0] s8_rest_reg;
    logic [23:0] s9_n_reg;   logic [17:0] s9_r_reg;   logic [23:0] s9_rest_reg;
    logic [23:0] s10_n_reg;  logic [29:0] s10_x_reg;  logic [11:0] s10_q_reg;
    logic [11:0] s10_rest_reg;
    logic [35:0] s11_n_reg;  logic [17:0] s11_r_reg;  logic [11:0] s11_rest_reg;
    logic [35:0] s12_n_reg;  logic [29:0] s12_x_reg;  logic [11:0] s12_q_reg;
    logic [30:0] s13_n400_reg; logic [17:0] s13_r_reg;
    logic [39:0] s14_y400_reg; logic [1:0] s14_n100_reg; logic [15:0] s14_r_reg;
    logic [39:0] s15_y400_reg; logic [1:0] s15_n100_reg; logic [15:0] s15_r_reg;
    logic [4:0]  s15_q_reg;
    logic [39:0] s16_y400_reg; logic [1:0] s16_n100_reg; logic [4:0] s16_n4_reg;
    logic [10:0] s16_r_reg;
    logic [39:0] s17_y_reg;  logic [8:0] s17_d_reg;
    logic [40:0] s18_year_reg; logic [8:0] s18_d_reg;
    logic [40:0] s19_mag_reg;  logic [40:0] s19_year_reg; logic [8:0] s19_d_reg;
    logic [21:0] s20_sum_reg;  logic [3:0] s20_low_reg; logic [40:0] s20_year_reg;
    logic [8:0]  s20_d_reg;
    logic [17:0] s21_q_reg;    logic [21:0] s21_sum_reg; logic [3:0] s21_low_reg;
    logic [40:0] s21_year_reg; logic [8:0] s21_d_reg;
    logic        s22_leap_reg; logic [40:0] s22_year_reg; logic [8:0] s22_d_reg;
    logic        s23_spec_reg; logic [8:0] s23_dd_reg; logic [3:0] s23_m_reg;
    logic [40:0] s23_year_reg; logic [8:0] s23_d_reg;
    sgd_result_t s24_res_reg;

    logic [28:0] x1_next, x3_next, x5_next;
    logic [29:0] x6_next, x8_next, x10_next, x12_next;
    logic [47:0] n400_wide;
    logic [1:0]  n100_next;
    logic [15:0] r100_next;
    logic [39:0] y400_next;
    logic [1:0]  n1_next;
    logic [8:0]  d_next;
    logic [39:0] y_next;
    logic [40:0] year_next, mag_next;
    logic [21:0] sum_next, m25_diff;
    logic [4:0]  m25_next;
    logic        leap_next;
    logic        spec_next;
    logic [8:0]  dd_next;
    logic [18:0] mon_prod;
    logic [4:0]  mon_est;
    logic [3:0]  m_next;
    logic [8:0]  end_days, start_days, mday0;
    logic [3:0]  mon0;
    sgd_result_t res_next;

    assign x1_next  = {10'd0, in_seconds[63:45]};
    assign x3_next  = {s2_r_reg, s2_sec_reg[37:19]};
    assign x5_next  = {s4_r_reg, s4_sec_reg};
    assign x6_next  = {18'd0, s5_day_reg[47:36]};
    assign x8_next  = {s7_r_reg, s7_rest_reg[35:24]};
    assign x10_next = {s9_r_reg, s9_rest_reg[23:12]};
    assign x12_next = {s11_r_reg, s11_rest_reg};
    assign n400_wide = {s12_n_reg, s12_q_reg};

    always_comb begin
        if (s13_r_reg >= 18'(3 * CENT_DAYS)) begin
            n100_next = 2'd3;
        end else if (s13_r_reg >= 18'(2 * CENT_DAYS)) begin
            n100_next = 2'd2;
        end else if (s13_r_reg >= 18'(CENT_DAYS)) begin
            n100_next = 2'd1;
        end else begin
            n100_next = 2'd0;
        end
        r100_next = 16'(s13_r_reg - 18'(n100_next) * 18'(CENT_DAYS));
        y400_next = {9'd0, s13_n400_reg} * 40'd400;
    end

    always_comb begin
        if (s16_r_reg >= 11'(3 * YEAR_DAYS)) begin
            n1_next = 2'd3;
        end else if (s16_r_reg >= 11'(2 * YEAR_DAYS)) begin
            n1_next = 2'd2;
        end else if (s16_r_reg >= 11'(YEAR_DAYS)) begin
            n1_next = 2'd1;
        end else begin
            n1_next = 2'd0;
        end
        d_next = 9'(s16_r_reg - 11'(n1_next) * 11'(YEAR_DAYS));
        y_next = s16_y400_reg + 40'(s16_n100_reg) * 40'd100
               + {33'd0, s16_n4_reg, 2'b00} + 40'(n1_next);
    end

    assign year_next = {1'b0, s17_y_reg} + {year_base[BASE_W-1], year_base};
    assign mag_next  = s18_year_reg[40] ? (~s18_year_reg + 41'd1) : s18_year_reg;
    assign sum_next  = 22'(s19_mag_reg[19:0]) + 22'(s19_mag_reg[39:20])
                     + 22'(s19_mag_reg[40]);
    assign m25_diff  = s21_sum_reg - 22'(s21_q_reg) * 22'd25;
    assign m25_next  = m25_diff[4:0];
    assign leap_next = (s21_low_reg[1:0] == 2'd0)
                     && ((m25_next != 5'd0) || (s21_low_reg == 4'd0));

    always_comb begin
        spec_next = s22_leap_reg && (s22_d_reg == LEAP_DAY);
        dd_next   = (s22_leap_reg && (s22_d_reg > LEAP_DAY)) ? s22_d_reg - 9'd1 : s22_d_reg;
        mon_prod  = {10'd0, dd_next} * {9'd0, MON_MAGIC};
        mon_est   = mon_prod[18:14];
        m_next    = (mon_est > 5'(LAST_MONTH)) ? LAST_MONTH : mon_est[3:0];
    end

    always_comb begin
        end_days   = cum_days(s23_m_reg + 4'd1);
        start_days = cum_days(s23_m_reg);
        if (s23_dd_reg >= end_days) begin
            mon0  = s23_m_reg + 4'd1;
            mday0 = s23_dd_reg - end_days;
        end else begin
            mon0  = s23_m_reg;
            mday0 = s23_dd_reg - start_days;
        end
        res_next.year = s23_year_reg;
        res_next.yday = s23_d_reg + 9'd1;
        if (!full_reg[STAGES-2]) begin
            res_next.month     = '0;
            res_next.month_day = '0;
        end else if (s23_spec_reg) begin
            res_next.month     = FEB;
            res_next.month_day = FEB_LAST;
        end else begin
            res_next.month     = mon0 + 4'd1;
            res_next.month_day = 5'(mday0 + 9'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            full_reg <= {full_reg[STAGES-2:0], in_full};

            s1_x_reg   <= x1_next;
            s1_q_reg   <= day_quot(x1_next);
            s1_sec_reg <= in_seconds[44:7];

            s2_hi_reg  <= s1_q_reg[9:0];
            s2_r_reg   <= day_rem(s1_x_reg, s1_q_reg);
            s2_sec_reg <= s1_sec_reg;

            s3_hi_reg  <= s2_hi_reg;
            s3_x_reg   <= x3_next;
            s3_q_reg   <= day_quot(x3_next);
            s3_sec_reg <= s2_sec_reg[18:0];

            s4_hi_reg  <= {s3_hi_reg, s3_q_reg};
            s4_r_reg   <= day_rem(s3_x_reg, s3_q_reg);
            s4_sec_reg <= s3_sec_reg;

            s5_day_reg <= {s4_hi_reg, day_quot(x5_next)};

            s6_x_reg    <= x6_next;
            s6_q_reg    <= cyc_quot(x6_next);
            s6_rest_reg <= s5_day_reg[35:0];

            s7_n_reg    <= s6_q_reg;
            s7_r_reg    <= cyc_rem(s6_x_reg, s6_q_reg);
            s7_rest_reg <= s6_rest_reg;

            s8_n_reg    <= s7_n_reg;
            s8_x_reg    <= x8_next;
            s8_q_reg    <= cyc_quot(x8_next);
            s8_rest_reg <= s7_rest_reg[23:0];

            s9_n_reg    <= {s8_n_reg, s8_q_reg};
            s9_r_reg    <= cyc_rem(s8_x_reg, s8_q_reg);
            s9_rest_reg <= s8_rest_reg;

            s10_n_reg    <= s9_n_reg;
            s10_x_reg    <= x10_next;
            s10_q_reg    <= cyc_quot(x10_next);
            s10_rest_reg <= s9_rest_reg[11:0];

            s11_n_reg    <= {s10_n_reg, s10_q_reg};
            s11_r_reg    <= cyc_rem(s10_x_reg, s10_q_reg);
            s11_rest_reg <= s10_rest_reg;

            s12_n_reg <= s11_n_reg;
            s12_x_reg <= x12_next;
            s12_q_reg <= cyc_quot(x12_next);

            s13_n400_reg <= n400_wide[30:0];
            s13_r_reg    <= cyc_rem(s12_x_reg, s12_q_reg);

            s14_y400_reg <= y400_next;
            s14_n100_reg <= n100_next;
            s14_r_reg    <= r100_next;

            s15_y400_reg <= s14_y400_reg;
            s15_n100_reg <= s14_n100_reg;
            s15_r_reg    <= s14_r_reg;
            s15_q_reg    <= quad_quot(s14_r_reg);

            s16_y400_reg <= s15_y400_reg;
            s16_n100_reg <= s15_n100_reg;
            s16_n4_reg   <= s15_q_reg;
            s16_r_reg    <= quad_rem(s15_r_reg, s15_q_reg);

            s17_y_reg <= y_next;
            s17_d_reg <= d_next;

            s18_year_reg <= year_next;
            s18_d_reg    <= s17_d_reg;

            s19_mag_reg  <= mag_next;
            s19_year_reg <= s18_year_reg;
            s19_d_reg    <= s18_d_reg;

            s20_sum_reg  <= sum_next;
            s20_low_reg  <= s19_mag_reg[3:0];
            s20_year_reg <= s19_year_reg;
            s20_d_reg    <= s19_d_reg;

            s21_q_reg    <= m25_quot(s20_sum_reg);
            s21_sum_reg  <= s20_sum_reg;
            s21_low_reg  <= s20_low_reg;
            s21_year_reg <= s20_year_reg;
            s21_d_reg    <= s20_d_reg;

            s22_leap_reg <= leap_next;
            s22_year_reg <= s21_year_reg;
            s22_d_reg    <= s21_d_reg;

            s23_spec_reg <= spec_next;
            s23_dd_reg   <= dd_next;
            s23_m_reg    <= m_next;
            s23_year_reg <= s22_year_reg;
            s23_d_reg    <= s22_d_reg;

            s24_res_reg <= res_next;
        end
    end

    assign out_valid  = vld_reg[STAGES-1];
    assign out_result = s24_res_reg;

endmodule

`default_nettype wire
